/* rtl/cist_pkg.sv */
// shared constants, codes and types of the can id subscription table
// used by cist_filter, cist_table and can_id_subscription_table; no dependencies
`default_nettype none

package cist_pkg;

	// field widths
	localparam int ID_W      = 11;
	localparam int ID_IN_W   = 16;
	localparam int TAG_W     = 8;
	localparam int DATA_W    = 64;
	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 3;
	localparam int SLOT_W    = 6;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 2;

	// stream port widths
	localparam int S_TDATA_W = 88;
	localparam int S_TUSER_W = CMD_W;
	localparam int M_TDATA_W = 96;
	localparam int M_TUSER_W = STATUS_W + 1;
	localparam int M_PAD_W   = M_TDATA_W - SLOT_W - TAG_W - ID_W - DATA_W;

	localparam logic [ID_W-1:0] ID_MASK = 11'h7FF;

	// commands
	localparam logic [CMD_W-1:0] CMD_SUBSCRIBE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_UNSUBSCRIBE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FRAME       = 2'd2;

	// result status
	localparam logic [STATUS_W-1:0] STS_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] STS_INVALID_ID = 3'd1;
	localparam logic [STATUS_W-1:0] STS_TABLE_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] STS_NOT_SUB    = 3'd3;
	localparam logic [STATUS_W-1:0] STS_NO_SUB     = 3'd4;
	localparam logic [STATUS_W-1:0] STS_FILTERED   = 3'd5;

	// filter modes
	localparam logic [MODE_W-1:0] FM_SINGLE = 2'd1;
	localparam logic [MODE_W-1:0] FM_RANGE  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_HIGH = 2'd2;

	typedef struct packed {
		logic            valid;
		logic [ID_W-1:0] ident;
	} tbl_entry_t;

	typedef struct packed {
		logic       vi_we;
		logic       hdl_we;
		tbl_entry_t entry;
	} tbl_wr_t;

endpackage

`default_nettype wire

/* rtl/cist_filter.sv */
// acceptance filter: derives code and mask from the filter registers and tests one id
// depends on cist_pkg
`default_nettype none

module cist_filter (
	input  logic [cist_pkg::MODE_W-1:0] mode,
	input  logic [cist_pkg::ID_W-1:0]   lo,
	input  logic [cist_pkg::ID_W-1:0]   hi,
	input  logic [cist_pkg::ID_W-1:0]   id,
	output logic                        accept
);
	import cist_pkg::*;

	logic [ID_W-1:0] diff;
	logic [ID_W-1:0] sm1;
	logic [ID_W-1:0] sm2;
	logic [ID_W-1:0] sm4;
	logic [ID_W-1:0] sm8;
	logic [ID_W-1:0] lo_min;
	logic [ID_W-1:0] mask;
	logic [ID_W-1:0] code;

	// smear the highest differing bit downward, the mask keeps the bits above it
	assign diff   = lo ^ hi;
	assign sm1    = diff | (diff >> 1);
	assign sm2    = sm1 | (sm1 >> 2);
	assign sm4    = sm2 | (sm2 >> 4);
	assign sm8    = sm4 | (sm4 >> 8);
	assign lo_min = (lo > hi) ? hi : lo;

	always_comb begin
		mask   = ID_MASK;
		code   = lo;
		accept = 1'b0;
		case (mode)
			FM_SINGLE: begin
				accept = ((id ^ code) & mask) == '0;
			end
			FM_RANGE: begin
				mask   = ~sm8 & ID_MASK;
				code   = lo_min & mask;
				accept = ((id ^ code) & mask) == '0;
			end
			default: begin
				accept = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/cist_table.sv */
// subscription table storage: valid/ident memory and handler memory, registered read
// depends on cist_pkg
`default_nettype none

module cist_table #(
	parameter int ENTRIES = 64,
	parameter int HDL_W   = 8,
	parameter int IDX_W   = 6
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [IDX_W-1:0]     rd_addr,
	output cist_pkg::tbl_entry_t rd_entry,
	output logic [HDL_W-1:0]     rd_hdl,
	input  cist_pkg::tbl_wr_t    wr,
	input  logic [IDX_W-1:0]     wr_addr,
	input  logic [HDL_W-1:0]     wr_hdl
);
	import cist_pkg::*;

	tbl_entry_t       vi_mem  [ENTRIES];
	logic [HDL_W-1:0] hdl_mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.vi_we) begin
			vi_mem[wr_addr] <= wr.entry;
		end
		if (rd_en) begin
			rd_entry <= vi_mem[rd_addr];
		end
	end

	// no clearing: a handler is only used from a valid entry, which wrote it
	always_ff @(posedge clk) begin
		if (wr.hdl_we) begin
			hdl_mem[wr_addr] <= wr_hdl;
		end
		if (rd_en) begin
			rd_hdl <= hdl_mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/can_id_subscription_table.sv */
// can id subscription table: acceptance filter, sequential table scan and result register
// depends on cist_pkg, cist_filter and cist_table
//
// usage:
//   s_axis carries one command beat: subscribe, unsubscribe or received frame (cmd in tuser).
//   m_axis returns exactly one result beat per command: status, delivered flag, slot,
//   handler, frame id and frame data.
//   cfg writes the filter registers (mode, low, high); cfg_ready is always high and a
//   write should only be made while no command is outstanding.
// sequence:
//   a command that passes the id and filter checks scans all TABLE_ENTRIES slots, one
//   memory read and one id compare per cycle, then goes through the tail and finish states;
//   its result is registered as it leaves finish and s_axis_tready rises in that same cycle.
//   a command rejected by the checks goes from idle straight to the finish state.
// reset:
//   arst_n clears the filter to accept none and starts a clearing pass over every table
//   slot, during which s_axis_tready is low.
// stalls:
//   a finished result waits in the output register while m_axis_tready is low; the next
//   command is still taken and scanned, and its result waits until the register frees.
`default_nettype none

module can_id_subscription_table #(
	parameter int TABLE_ENTRIES = 64,
	parameter int HANDLER_BITS  = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cist_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cist_pkg::ID_W-1:0]        cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// can_id[15:0], handler_tag[23:16], payload[87:24]
	input  logic [cist_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// cmd[1:0]
	input  logic [cist_pkg::S_TUSER_W-1:0]   s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// slot[5:0], handler_out[13:6], frame_id[24:14], frame_data[88:25], zero[95:89]
	output logic [cist_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	// status[2:0], delivered[3]
	output logic [cist_pkg::M_TUSER_W-1:0]   m_axis_tuser
);
	import cist_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES - 1);

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_TAIL   = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [MODE_W-1:0]        mode_q;
	logic [ID_W-1:0]          lo_q;
	logic [ID_W-1:0]          hi_q;

	logic [CMD_W-1:0]         cmd_q;
	logic [ID_W-1:0]          key_q;
	logic [HANDLER_BITS-1:0]  tag_q;
	logic [DATA_W-1:0]        data_q;
	logic                     early_q;
	logic [STATUS_W-1:0]      early_sts_q;

	logic                     found_q;
	logic [IDX_W-1:0]         found_idx_q;
	logic [HANDLER_BITS-1:0]  found_hdl_q;
	logic                     free_q;
	logic [IDX_W-1:0]         free_idx_q;

	logic                     rd_vld_s1;
	logic [IDX_W-1:0]         rd_idx_s1;

	logic                     out_valid_q;
	logic [M_TDATA_W-1:0]     out_tdata_q;
	logic [M_TUSER_W-1:0]     out_tuser_q;

	logic [CMD_W-1:0]         in_cmd;
	logic [ID_IN_W-1:0]       in_id;
	logic [TAG_W-1:0]         in_tag;
	logic [DATA_W-1:0]        in_data;
	logic                     s_fire;
	logic                     id_ok;
	logic                     flt_accept;
	logic                     early_d;
	logic [STATUS_W-1:0]      early_sts_d;

	logic                     rd_en;
	logic [IDX_W-1:0]         rd_addr;
	tbl_entry_t               rd_entry;
	logic [HANDLER_BITS-1:0]  rd_hdl;
	logic                     hit;
	logic                     empty;

	tbl_wr_t                  wr;
	logic [IDX_W-1:0]         wr_addr;
	logic                     fin_go;

	logic [STATUS_W-1:0]      r_status;
	logic                     r_deliv;
	logic [SLOT_W-1:0]        r_slot;
	logic [TAG_W-1:0]         r_hdl;
	logic [ID_W-1:0]          r_fid;
	logic [DATA_W-1:0]        r_fdata;

	assign in_cmd  = s_axis_tuser;
	assign in_id   = s_axis_tdata[ID_IN_W-1:0];
	assign in_tag  = s_axis_tdata[ID_IN_W+TAG_W-1:ID_IN_W];
	assign in_data = s_axis_tdata[ID_IN_W+TAG_W+DATA_W-1:ID_IN_W+TAG_W];

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_tdata_q;
	assign m_axis_tuser  = out_tuser_q;
	assign fin_go        = !out_valid_q || m_axis_tready;

	cist_filter u_filter (
		.mode   (mode_q),
		.lo     (lo_q),
		.hi     (hi_q),
		.id     (in_id[ID_W-1:0]),
		.accept (flt_accept)
	);

	assign id_ok = (in_id[ID_IN_W-1:ID_W] == '0);

	// commands settled by the id and filter checks skip the scan
	always_comb begin
		early_d     = 1'b1;
		early_sts_d = STS_INVALID_ID;
		case (in_cmd)
			CMD_SUBSCRIBE: begin
				early_d = !(id_ok && flt_accept);
			end
			CMD_UNSUBSCRIBE: begin
				early_d = !id_ok;
			end
			CMD_FRAME: begin
				early_d = !flt_accept;
				early_sts_d = STS_FILTERED;
			end
			default: begin
				early_d = 1'b1;
			end
		endcase
	end

	assign rd_en   = (state_q == ST_SCAN);
	assign rd_addr = cnt_q[IDX_W-1:0];

	cist_table #(
		.ENTRIES (TABLE_ENTRIES),
		.HDL_W   (HANDLER_BITS),
		.IDX_W   (IDX_W)
	) u_table (
		.clk      (clk),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry),
		.rd_hdl   (rd_hdl),
		.wr       (wr),
		.wr_addr  (wr_addr),
		.wr_hdl   (tag_q)
	);

	// shared compare on the entry read in the previous cycle
	assign hit   = rd_vld_s1 && rd_entry.valid && (rd_entry.ident == key_q);
	assign empty = rd_vld_s1 && !rd_entry.valid;

	always_comb begin
		wr       = '0;
		wr_addr  = found_idx_q;
		r_status = STS_INVALID_ID;
		r_deliv  = 1'b0;
		r_slot   = '0;
		r_hdl    = '0;
		r_fid    = '0;
		r_fdata  = '0;
		if (state_q == ST_CLEAR) begin
			wr.vi_we = 1'b1;
			wr_addr  = cnt_q[IDX_W-1:0];
		end else if (state_q == ST_FINISH && early_q) begin
			r_status = early_sts_q;
		end else if (state_q == ST_FINISH) begin
			case (cmd_q)
				CMD_SUBSCRIBE: begin
					if (found_q) begin
						wr.hdl_we = 1'b1;
						r_status  = STS_OK;
						r_slot    = SLOT_W'(found_idx_q);
					end else if (free_q) begin
						wr.vi_we        = 1'b1;
						wr.hdl_we       = 1'b1;
						wr.entry.valid  = 1'b1;
						wr.entry.ident  = key_q;
						wr_addr         = free_idx_q;
						r_status        = STS_OK;
						r_slot          = SLOT_W'(free_idx_q);
					end else begin
						r_status = STS_TABLE_FULL;
					end
				end
				CMD_UNSUBSCRIBE: begin
					if (found_q) begin
						wr.vi_we = 1'b1;
						r_status = STS_OK;
						r_slot   = SLOT_W'(found_idx_q);
					end else begin
						r_status = STS_NOT_SUB;
					end
				end
				CMD_FRAME: begin
					if (found_q) begin
						r_status = STS_OK;
						r_deliv  = 1'b1;
						r_slot   = SLOT_W'(found_idx_q);
						r_hdl    = TAG_W'(found_hdl_q);
						r_fid    = key_q;
						r_fdata  = data_q;
					end else begin
						r_status = STS_NO_SUB;
					end
				end
				default: begin
					r_status = STS_INVALID_ID;
				end
			endcase
			if (!fin_go) begin
				wr.vi_we  = 1'b0;
				wr.hdl_we = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			mode_q      <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			early_q     <= 1'b0;
			found_q     <= 1'b0;
			free_q      <= 1'b0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FILTER_MODE: mode_q <= cfg_data[MODE_W-1:0];
					REG_FILTER_LOW:  lo_q <= cfg_data;
					REG_FILTER_HIGH: hi_q <= cfg_data;
					default: begin
					end
				endcase
			end
			rd_vld_s1 <= rd_en;
			if (state_q == ST_FINISH && fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			// first match and first free slot win
			if (hit) begin
				found_q <= 1'b1;
			end
			if (empty) begin
				free_q <= 1'b1;
			end
			case (state_q)
				ST_CLEAR: begin
					if (cnt_q == LAST_CNT) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (s_fire) begin
						found_q <= 1'b0;
						free_q  <= 1'b0;
						early_q <= early_d;
						cnt_q   <= '0;
						state_q <= early_d ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cnt_q == LAST_CNT) begin
						state_q <= ST_TAIL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_TAIL: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_q       <= in_cmd;
			key_q       <= in_id[ID_W-1:0];
			tag_q       <= HANDLER_BITS'(in_tag);
			data_q      <= in_data;
			early_sts_q <= early_sts_d;
		end
		rd_idx_s1 <= rd_addr;
		if (hit && !found_q) begin
			found_idx_q <= rd_idx_s1;
			found_hdl_q <= rd_hdl;
		end
		if (empty && !free_q) begin
			free_idx_q <= rd_idx_s1;
		end
		if (state_q == ST_FINISH && fin_go) begin
			out_tdata_q <= {{M_PAD_W{1'b0}}, r_fdata, r_fid, r_hdl, r_slot};
			out_tuser_q <= {r_deliv, r_status};
		end
	end

`ifndef SYNTHESIS
	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> (state_q == ST_SCAN || state_q == ST_FINISH))
		else $error("accepted beat did not start a scan or finish");

	a_read_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SCAN || state_q == ST_TAIL))
		else $error("table read data outside the scan");

	a_no_write_during_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && (wr.vi_we || wr.hdl_we)) |-> !rd_vld_s1)
		else $error("table write while a scan read is in flight");

	a_delivered_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[STATUS_W]) |-> (m_axis_tuser[STATUS_W-1:0] == STS_OK))
		else $error("delivered frame without ok status");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for can_id_subscription_table: filter, subscribe, unsubscribe and frame dispatch
// depends on cist_pkg and can_id_subscription_table; keeps its own shadow of the table and filter

module testbench;
	import cist_pkg::*;

	localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
	localparam logic [MODE_W-1:0] FM_NONE    = 2'd0;
	localparam logic [MODE_W-1:0] FM_UNUSED  = 2'd3;
	localparam int ENTRIES   = 64;
	localparam int POOL      = 100;
	localparam int MAX_GAP   = 13;
	localparam int LONG_HOLD = 400;
	localparam int TAIL      = 70;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                delivered;
		logic [SLOT_W-1:0]   slot;
		logic [TAG_W-1:0]    handler;
		logic [ID_W-1:0]     frame_id;
		logic [DATA_W-1:0]   frame_data;
	} reply_t;

	class subscription_shadow;
		logic [MODE_W-1:0] mode;
		logic [ID_W-1:0]   low_end;
		logic [ID_W-1:0]   high_end;
		bit                in_use [ENTRIES];
		logic [ID_W-1:0]   ident [ENTRIES];
		logic [TAG_W-1:0]  handler [ENTRIES];
		reply_t            pending_replies [$];
		int                errors;
		int                replies_seen;

		function new();
			mode = FM_NONE;
			low_end = '0;
			high_end = '0;
			errors = 0;
			replies_seen = 0;
			foreach (in_use[i]) begin
				in_use[i] = 1'b0;
				ident[i] = '0;
				handler[i] = '0;
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] data);
			case (idx)
				REG_FILTER_MODE: mode = data[MODE_W-1:0];
				REG_FILTER_LOW: low_end = data;
				REG_FILTER_HIGH: high_end = data;
				default: ;
			endcase
		endfunction

		// the two range ends agree above their top differing bit, so their order does not matter
		function bit accepts(logic [ID_W-1:0] id);
			logic [ID_W-1:0] diff;
			logic [ID_W-1:0] keep;
			diff = low_end ^ high_end;
			keep = ID_MASK;
			if (mode == FM_SINGLE)
				return id == low_end;
			if (mode != FM_RANGE)
				return 1'b0;
			for (int k = 0; k < ID_W; k++)
				if (diff[k])
					keep = ID_MASK << (k + 1);
			return (id & keep) == (low_end & keep);
		endfunction

		function int find_ident(logic [ID_W-1:0] id);
			for (int i = 0; i < ENTRIES; i++)
				if (in_use[i] && ident[i] == id)
					return i;
			return -1;
		endfunction

		function void note_command(logic [CMD_W-1:0] cmd, logic [ID_IN_W-1:0] id,
				logic [TAG_W-1:0] tag, logic [DATA_W-1:0] payload);
			reply_t r;
			int at;
			r = '0;
			r.status = STS_INVALID_ID;
			at = -1;
			case (cmd)
				CMD_SUBSCRIBE: begin
					if (id[ID_IN_W-1:ID_W] == '0 && accepts(id[ID_W-1:0])) begin
						at = find_ident(id[ID_W-1:0]);
						if (at < 0) begin
							// lowest free slot wins
							for (int i = ENTRIES - 1; i >= 0; i--)
								if (!in_use[i])
									at = i;
							if (at >= 0) begin
								in_use[at] = 1'b1;
								ident[at] = id[ID_W-1:0];
							end
						end
						if (at < 0) begin
							r.status = STS_TABLE_FULL;
						end else begin
							handler[at] = tag;
							r.status = STS_OK;
							r.slot = SLOT_W'(at);
						end
					end
				end
				CMD_UNSUBSCRIBE: begin
					if (id[ID_IN_W-1:ID_W] == '0) begin
						at = find_ident(id[ID_W-1:0]);
						if (at < 0) begin
							r.status = STS_NOT_SUB;
						end else begin
							in_use[at] = 1'b0;
							ident[at] = '0;
							r.status = STS_OK;
							r.slot = SLOT_W'(at);
						end
					end
				end
				CMD_FRAME: begin
					// upper id bits of a frame are ignored
					if (!accepts(id[ID_W-1:0])) begin
						r.status = STS_FILTERED;
					end else begin
						at = find_ident(id[ID_W-1:0]);
						if (at < 0) begin
							r.status = STS_NO_SUB;
						end else begin
							r.status = STS_OK;
							r.delivered = 1'b1;
							r.slot = SLOT_W'(at);
							r.handler = handler[at];
							r.frame_id = id[ID_W-1:0];
							r.frame_data = payload;
						end
					end
				end
				default: ;
			endcase
			pending_replies.push_back(r);
		endfunction

		function void check_reply(logic [M_TUSER_W-1:0] user, logic [M_TDATA_W-1:0] data);
			reply_t got;
			reply_t want;
			got.status = user[2:0];
			got.delivered = user[3];
			got.slot = data[5:0];
			got.handler = data[13:6];
			got.frame_id = data[24:14];
			got.frame_data = data[88:25];
			replies_seen++;
			if (pending_replies.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result %0d arrived with nothing outstanding", replies_seen);
				return;
			end
			want = pending_replies.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) begin
					$display("result %0d: expected status %0d dlv %0d slot %0d hdl %h id %h data %h",
						replies_seen, want.status, want.delivered, want.slot, want.handler,
						want.frame_id, want.frame_data);
					$display("result %0d: actual   status %0d dlv %0d slot %0d hdl %h id %h data %h",
						replies_seen, got.status, got.delivered, got.slot, got.handler,
						got.frame_id, got.frame_data);
				end
			end
		endfunction

		function int outstanding();
			return pending_replies.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [ID_W-1:0]        cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
	logic [S_TUSER_W-1:0]   s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_axis_tdata;
	logic [M_TUSER_W-1:0]   m_axis_tuser;

	subscription_shadow shadow = new();
	logic [ID_W-1:0] id_pool [POOL];
	int sent = 0;

	can_id_subscription_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (cfg_valid && cfg_ready)
			shadow.write_reg(cfg_index, cfg_data);
		if (s_axis_tvalid && s_axis_tready)
			shadow.note_command(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[23:16],
				s_axis_tdata[87:24]);
		if (m_axis_tvalid && m_axis_tready)
			shadow.check_reply(m_axis_tuser, m_axis_tdata);
	end

	// result side: random stalls, bursts without stalls and one long hold-off
	initial begin
		int taken;
		int gap;
		taken = 0;
		forever begin
			if (taken == 120)
				gap = LONG_HOLD;
			else if (taken % 90 < 15)
				gap = 0;
			else
				gap = $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			taken++;
		end
	end

	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [ID_IN_W-1:0] id,
			input logic [TAG_W-1:0] tag, input logic [DATA_W-1:0] payload);
		int gap;
		gap = (sent % 100 < 15) ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {payload, tag, id};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
	endtask

	// hold the command side until every result is back and the block takes input again
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (shadow.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic write_filter(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] lo,
			input logic [ID_W-1:0] hi);
		logic [CFG_IDX_W-1:0] idx [3];
		logic [ID_W-1:0] val [3];
		idx = '{REG_FILTER_MODE, REG_FILTER_LOW, REG_FILTER_HIGH};
		val = '{ID_W'(mode), lo, hi};
		for (int r = 0; r < 3; r++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[r];
			cfg_data <= val[r];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// mostly ids from a shared pool so entries get hit, refilled and the table runs full
	task automatic send_random();
		int pick;
		logic [CMD_W-1:0] cmd;
		logic [ID_IN_W-1:0] id;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			cmd = CMD_SUBSCRIBE;
		else if (pick < 65)
			cmd = CMD_UNSUBSCRIBE;
		else if (pick < 95)
			cmd = CMD_FRAME;
		else
			cmd = CMD_UNUSED;
		pick = $urandom_range(0, 99);
		if (pick < 85)
			id = {5'd0, id_pool[$urandom_range(0, POOL - 1)]};
		else if (pick < 93)
			id = ID_IN_W'($urandom_range(0, 16'hFFFF));
		else
			id = {5'($urandom), id_pool[$urandom_range(0, POOL - 1)]};
		send_command(cmd, id, TAG_W'($urandom), {$urandom, $urandom});
	endtask

	task automatic run_phase(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] lo,
			input logic [ID_W-1:0] hi, input int count);
		settle();
		write_filter(mode, lo, hi);
		repeat (count) send_random();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		id_pool[0] = '0;
		id_pool[1] = ID_MASK;
		id_pool[2] = 11'h155;
		id_pool[3] = 11'h123;
		for (int i = 4; i < POOL; i++)
			id_pool[i] = (i < 14) ? ID_W'(11'h280 + $urandom_range(0, 127)) : ID_W'($urandom);

		// filter still accepts nothing after reset
		send_command(CMD_SUBSCRIBE, 16'h0005, 8'h11, '0);
		send_command(CMD_FRAME, 16'h0005, 8'h00, 64'h0123_4567_89AB_CDEF);
		send_command(CMD_UNSUBSCRIBE, 16'h0005, 8'h00, '0);
		send_command(CMD_UNSUBSCRIBE, 16'hFFFF, 8'hFF, '1);
		send_command(CMD_UNUSED, 16'h0001, 8'h22, '0);

		// full range: everything passes
		settle();
		write_filter(FM_RANGE, '0, ID_MASK);
		send_command(CMD_SUBSCRIBE, 16'h0000, 8'hFF, '0);
		send_command(CMD_SUBSCRIBE, 16'h07FF, 8'h00, '0);
		send_command(CMD_SUBSCRIBE, 16'h0800, 8'h33, '0);
		send_command(CMD_SUBSCRIBE, 16'hFFFF, 8'h44, '0);
		send_command(CMD_SUBSCRIBE, 16'h0000, 8'h5A, '0);
		send_command(CMD_FRAME, 16'h0000, 8'h00, '1);
		send_command(CMD_FRAME, 16'hF7FF, 8'hFF, '0);
		send_command(CMD_FRAME, 16'h0123, 8'h00, {$urandom, $urandom});
		send_command(CMD_UNSUBSCRIBE, 16'h07FF, 8'h00, '0);
		send_command(CMD_UNSUBSCRIBE, 16'h07FF, 8'h00, '0);
		send_command(CMD_FRAME, 16'h07FF, 8'h00, '1);
		send_command(CMD_SUBSCRIBE, 16'h07FF, 8'hA5, '0);
		send_command(CMD_FRAME, 16'hFFFF, 8'h00, {$urandom, $urandom});

		// single id: other ids refused, unsubscribe skips the filter
		settle();
		write_filter(FM_SINGLE, 11'h123, '0);
		send_command(CMD_SUBSCRIBE, 16'h0124, 8'h01, '0);
		send_command(CMD_SUBSCRIBE, 16'h0123, 8'h3C, '0);
		send_command(CMD_FRAME, 16'h0000, 8'h00, '1);
		send_command(CMD_FRAME, 16'h0123, 8'h00, {$urandom, $urandom});
		send_command(CMD_UNSUBSCRIBE, 16'h0000, 8'h00, '0);

		run_phase(FM_RANGE, '0, ID_MASK, 260);
		run_phase(FM_SINGLE, id_pool[$urandom_range(4, POOL - 1)], '0, 90);
		run_phase(FM_RANGE, 11'h2C0, 11'h2A0, 90);
		run_phase(FM_RANGE, 11'h155, 11'h155, 90);
		run_phase(FM_UNUSED, ID_MASK, ID_MASK, 70);
		run_phase(FM_NONE, '0, '0, 60);
		run_phase(FM_RANGE, ID_MASK, '0, 120);
		run_phase(FM_SINGLE, ID_MASK, ID_MASK, 60);
		run_phase(FM_RANGE, ID_W'($urandom), ID_W'($urandom), 90);

		settle();
		repeat (TAIL) @(posedge clk);
		if (shadow.errors == 0 && shadow.outstanding() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
